FILE: hw/rtl/gasp_pkg.sv
// Package for the grid path search block: payload structs, controller commands,
// status struct and sizing constants. No dependencies.
package gasp_pkg;

    localparam int MAX_DIM_DEF     = 8;
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int CELLS           = 64;
    localparam int CELL_W          = 6;
    localparam int COST_W          = 7;
    localparam int PRIO_W          = 7;
    localparam int QENT_W          = PRIO_W + CELL_W;

    typedef struct packed {
        logic       mode;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
        logic       blocked;
        logic [2:0] goal_x;
        logic [2:0] goal_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0] path_x;
        logic [2:0] path_y;
        logic       last;
        logic       reached;
    } t_out_item;

    typedef logic [4:0] t_cmd;

    localparam t_cmd C_NOP    = 5'd0;
    localparam t_cmd C_ACCEPT = 5'd1;   // latch item, write obstacle in mode 0
    localparam t_cmd C_INIT   = 5'd2;   // clear stores, seed queue with start
    localparam t_cmd C_SCAN0  = 5'd3;   // idx = 0
    localparam t_cmd C_SRD    = 5'd4;   // read queue[idx]
    localparam t_cmd C_SCMP   = 5'd5;   // compare entry, idx++
    localparam t_cmd C_POP    = 5'd6;   // cur = best cell, idx = best index
    localparam t_cmd C_SHRD   = 5'd7;   // read queue[idx+1], or drop count when done
    localparam t_cmd C_SHWR   = 5'd8;   // queue[idx] = read data, idx++
    localparam t_cmd C_CRD    = 5'd9;   // read cost[cur], k = 0
    localparam t_cmd C_CLAT   = 5'd10;  // latch cost of cur
    localparam t_cmd C_NB     = 5'd11;  // form neighbor, read its stores
    localparam t_cmd C_NCHK   = 5'd12;  // relax neighbor, k++
    localparam t_cmd C_MISS   = 5'd13;  // emit goal-only result
    localparam t_cmd C_CH0    = 5'd14;  // chain[0] = goal
    localparam t_cmd C_CHRD   = 5'd15;  // read came_from[c]
    localparam t_cmd C_CHL    = 5'd16;  // chain[n] = parent, n++
    localparam t_cmd C_ORD    = 5'd17;  // read chain entry for output
    localparam t_cmd C_OEM    = 5'd18;  // emit path cell

    typedef struct packed {
        logic mode1;
        logic cnt_zero;
        logic scan_last;
        logic shift_done;
        logic cur_is_goal;
        logic nb_oob;
        logic k_last;
        logic goal_valid;
        logic chain_done;
        logic out_last;
    } t_stat;

endpackage

FILE: hw/rtl/gasp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gasp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

FILE: hw/rtl/gasp_dp.sv
// Datapath of the grid path search: stores, open queue, neighbor logic, path walk.
// Depends on gasp_pkg and gasp_ram.
module gasp_dp #(
    parameter int MAX_DIM     = gasp_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = gasp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gasp_pkg::t_cmd      i_cmd,
    input  gasp_pkg::t_in_item  i_item,
    input  logic [3:0]          i_grid_w,
    input  logic [3:0]          i_grid_h,
    output gasp_pkg::t_stat     o_stat,
    output logic                o_strobe,
    output gasp_pkg::t_out_item o_result
);
    import gasp_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [3:0] MaxDim = 4'(MAX_DIM);

    logic [CELL_W-1:0] r_s, r_g, r_cur, r_nb, r_c, r_best_cell;
    logic [2:0]        r_gx, r_gy;
    logic [QCW-1:0]    r_cnt;
    logic [QAW-1:0]    r_idx, r_best_idx;
    logic [PRIO_W-1:0] r_best_prio;
    logic [COST_W-1:0] r_ccost;
    logic [1:0]        r_k;
    logic [6:0]        r_n, r_ok;
    logic [CELLS-1:0]  r_cvalid, r_ovalid;
    logic              r_strobe;
    t_out_item         r_res;

    logic [QENT_W-1:0] q_rd;
    logic [COST_W-1:0] cost_rd;
    logic [CELL_W-1:0] from_rd, chain_rd;
    logic              obst_rd;

    // neighbor formation
    logic [3:0] w_eff, h_eff, nx4, ny4;
    logic [2:0] cx, cy;
    logic [1:0] d;
    logic       oob;
    logic [CELL_W-1:0] nb;
    logic [COST_W-1:0] nc;
    logic [2:0] dx, dy;
    logic [PRIO_W-1:0] prio;
    logic       improve;

    assign w_eff = (i_grid_w > MaxDim) ? MaxDim : i_grid_w;
    assign h_eff = (i_grid_h > MaxDim) ? MaxDim : i_grid_h;
    assign cx = r_cur[2:0];
    assign cy = r_cur[5:3];
    assign d  = (cx[0] == cy[0]) ? (2'd3 - r_k) : r_k;

    always_comb begin
        nx4 = {1'b0, cx};
        ny4 = {1'b0, cy};
        oob = 1'b0;
        case (d)
            2'd0: begin
                ny4 = {1'b0, cy} - 4'd1;
                oob = (cy == 3'd0);
            end
            2'd1: begin
                nx4 = {1'b0, cx} - 4'd1;
                oob = (cx == 3'd0);
            end
            2'd2: ny4 = {1'b0, cy} + 4'd1;
            default: nx4 = {1'b0, cx} + 4'd1;
        endcase
        if (nx4 >= w_eff || ny4 >= h_eff) begin
            oob = 1'b1;
        end
    end

    assign nb   = {ny4[2:0], nx4[2:0]};
    assign nc   = r_ccost + 7'd1;
    assign dx   = (r_nb[2:0] > r_gx) ? (r_nb[2:0] - r_gx) : (r_gx - r_nb[2:0]);
    assign dy   = (r_nb[5:3] > r_gy) ? (r_nb[5:3] - r_gy) : (r_gy - r_nb[5:3]);
    assign prio = nc + 7'(dx) + 7'(dy);
    assign improve = !(r_ovalid[r_nb] && obst_rd) && (!r_cvalid[r_nb] || nc < cost_rd);

    // memory ports
    logic              q_we, cost_we, from_we, chain_we, obst_we;
    logic [QAW-1:0]    q_wa, q_ra;
    logic [QENT_W-1:0] q_wd;
    logic [CELL_W-1:0] cost_wa, cost_ra, from_wa, chain_wa, chain_ra;
    logic [COST_W-1:0] cost_wd;
    logic [CELL_W-1:0] from_wd, chain_wd, obst_wa;

    always_comb begin
        q_we = 1'b0; q_wa = '0; q_wd = '0;
        cost_we = 1'b0; cost_wa = r_s; cost_wd = '0;
        from_we = 1'b0; from_wa = r_s; from_wd = r_s;
        chain_we = 1'b0; chain_wa = '0; chain_wd = r_g;
        obst_we = (i_cmd == C_ACCEPT) && !i_item.mode;
        obst_wa = {i_item.cell_y, i_item.cell_x};
        q_ra = (i_cmd == C_SHRD) ? QAW'(r_idx + 1'b1) : r_idx;
        cost_ra = (i_cmd == C_CRD) ? r_cur : nb;
        chain_ra = 6'(r_n - r_ok - 7'd1);
        case (i_cmd)
            C_INIT: begin
                q_we = 1'b1;
                q_wd = {7'd0, r_s};
                cost_we = 1'b1;
                from_we = 1'b1;
            end
            C_SHWR: begin
                q_we = 1'b1;
                q_wa = r_idx;
                q_wd = q_rd;
            end
            C_NCHK: begin
                if (improve) begin
                    q_we = (r_cnt < QCW'(QUEUE_DEPTH));
                    q_wa = r_cnt[QAW-1:0];
                    q_wd = {prio, r_nb};
                    cost_we = 1'b1; cost_wa = r_nb; cost_wd = nc;
                    from_we = 1'b1; from_wa = r_nb; from_wd = r_cur;
                end
            end
            C_CH0: chain_we = 1'b1;
            C_CHL: begin
                chain_we = 1'b1;
                chain_wa = r_n[5:0];
                chain_wd = from_rd;
            end
            default: ;
        endcase
    end

    gasp_ram #(.WIDTH(QENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd), .i_raddr(q_ra), .o_rdata(q_rd));
    gasp_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost (
        .i_clk, .i_we(cost_we), .i_waddr(cost_wa), .i_wdata(cost_wd), .i_raddr(cost_ra),
        .o_rdata(cost_rd));
    gasp_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_from (
        .i_clk, .i_we(from_we), .i_waddr(from_wa), .i_wdata(from_wd), .i_raddr(r_c),
        .o_rdata(from_rd));
    gasp_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_chain (
        .i_clk, .i_we(chain_we), .i_waddr(chain_wa), .i_wdata(chain_wd), .i_raddr(chain_ra),
        .o_rdata(chain_rd));
    gasp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obst (
        .i_clk, .i_we(obst_we), .i_waddr(obst_wa), .i_wdata(i_item.blocked), .i_raddr(nb),
        .o_rdata(obst_rd));

    // status
    assign o_stat.mode1       = i_item.mode;
    assign o_stat.cnt_zero    = (r_cnt == '0);
    assign o_stat.scan_last   = (QCW'(r_idx) + 1'b1 >= r_cnt);
    assign o_stat.shift_done  = (QCW'(r_idx) + 1'b1 >= r_cnt);
    assign o_stat.cur_is_goal = (r_cur == r_g);
    assign o_stat.nb_oob      = oob;
    assign o_stat.k_last      = (r_k == 2'd3);
    assign o_stat.goal_valid  = r_cvalid[r_g];
    assign o_stat.chain_done  = (r_c == r_s) || (r_n == 7'd64);
    assign o_stat.out_last    = (r_ok + 7'd1 == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= '0;
            r_cvalid <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd == C_MISS) || (i_cmd == C_OEM);
            case (i_cmd)
                C_ACCEPT: begin
                    r_s  <= {i_item.cell_y, i_item.cell_x};
                    r_g  <= {i_item.goal_y, i_item.goal_x};
                    r_gx <= i_item.goal_x;
                    r_gy <= i_item.goal_y;
                    if (!i_item.mode) begin
                        r_ovalid[{i_item.cell_y, i_item.cell_x}] <= 1'b1;
                    end
                end
                C_INIT: begin
                    // only the start cell has a cost at the outset
                    r_cvalid <= CELLS'(1) << r_s;
                    r_cnt <= QCW'(1);
                end
                C_SCAN0: r_idx <= '0;
                C_SCMP: begin
                    if (r_idx == '0 || q_rd[QENT_W-1:CELL_W] <= r_best_prio) begin
                        r_best_prio <= q_rd[QENT_W-1:CELL_W];
                        r_best_idx  <= r_idx;
                        r_best_cell <= q_rd[CELL_W-1:0];
                    end
                    r_idx <= r_idx + 1'b1;
                end
                C_POP: begin
                    r_cur <= r_best_cell;
                    r_idx <= r_best_idx;
                end
                C_SHRD: begin
                    if (QCW'(r_idx) + 1'b1 >= r_cnt) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                C_SHWR: r_idx <= r_idx + 1'b1;
                C_CRD:  r_k <= 2'd0;
                C_CLAT: r_ccost <= cost_rd;
                C_NB: begin
                    r_nb <= nb;
                    if (oob) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                C_NCHK: begin
                    if (improve) begin
                        r_cvalid[r_nb] <= 1'b1;
                        if (r_cnt < QCW'(QUEUE_DEPTH)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    r_k <= r_k + 1'b1;
                end
                C_MISS: begin
                    r_res <= '{path_x: r_gx, path_y: r_gy, last: 1'b1, reached: 1'b0};
                end
                C_CH0: begin
                    r_c  <= r_g;
                    r_n  <= 7'd1;
                    r_ok <= 7'd0;
                end
                C_CHL: begin
                    r_c <= from_rd;
                    r_n <= r_n + 7'd1;
                end
                C_OEM: begin
                    r_res <= '{path_x: chain_rd[2:0], path_y: chain_rd[5:3],
                               last: (r_ok + 7'd1 == r_n), reached: 1'b1};
                    r_ok <= r_ok + 7'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;
endmodule

FILE: hw/rtl/gasp_ctrl.sv
// Controller state machine of the grid path search: sequences datapath commands.
// Depends on gasp_pkg.
module gasp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  gasp_pkg::t_stat i_stat,
    output gasp_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import gasp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_PCHK = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_SCMP = 4'd4;
    localparam logic [3:0] S_POP  = 4'd5;
    localparam logic [3:0] S_SHRD = 4'd6;
    localparam logic [3:0] S_SHWR = 4'd7;
    localparam logic [3:0] S_EXP  = 4'd8;
    localparam logic [3:0] S_CLAT = 4'd9;
    localparam logic [3:0] S_NB   = 4'd10;
    localparam logic [3:0] S_NCHK = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_CHK  = 4'd13;
    localparam logic [3:0] S_CHL  = 4'd14;
    localparam logic [3:0] S_ORD  = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_oem, n_oem;   // output emit sub-step after S_ORD

    always_comb begin
        n_state = r_state;
        n_oem   = 1'b0;
        o_cmd   = C_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd = C_ACCEPT;
                    if (i_stat.mode1) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd = C_INIT;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd = C_SCAN0;
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd = C_SRD;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                o_cmd = C_SCMP;
                n_state = i_stat.scan_last ? S_POP : S_SRD;
            end
            S_POP: begin
                o_cmd = C_POP;
                n_state = S_SHRD;
            end
            S_SHRD: begin
                o_cmd = C_SHRD;
                n_state = i_stat.shift_done ? S_EXP : S_SHWR;
            end
            S_SHWR: begin
                o_cmd = C_SHWR;
                n_state = S_SHRD;
            end
            S_EXP: begin
                if (i_stat.cur_is_goal) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd = C_CRD;
                    n_state = S_CLAT;
                end
            end
            S_CLAT: begin
                o_cmd = C_CLAT;
                n_state = S_NB;
            end
            S_NB: begin
                o_cmd = C_NB;
                if (!i_stat.nb_oob) begin
                    n_state = S_NCHK;
                end else if (i_stat.k_last) begin
                    n_state = S_PCHK;
                end
            end
            S_NCHK: begin
                o_cmd = C_NCHK;
                n_state = i_stat.k_last ? S_PCHK : S_NB;
            end
            S_FIN: begin
                if (i_stat.goal_valid) begin
                    o_cmd = C_CH0;
                    n_state = S_CHK;
                end else begin
                    o_cmd = C_MISS;
                    n_state = S_IDLE;
                end
            end
            S_CHK: begin
                o_cmd = C_CHRD;
                n_state = i_stat.chain_done ? S_ORD : S_CHL;
            end
            S_CHL: begin
                o_cmd = C_CHL;
                n_state = S_CHK;
            end
            S_ORD: begin
                if (!r_oem) begin
                    o_cmd = C_ORD;
                    n_oem = 1'b1;
                end else begin
                    o_cmd = C_OEM;
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oem   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oem   <= n_oem;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

FILE: hw/rtl/grid_astar_path_search.sv
// Top level of the grid path search block: APB register file, controller, datapath.
// Depends on gasp_pkg, gasp_ctrl, gasp_dp (and gasp_ram through the datapath).
//
// Use:
//   An item is taken at an edge with start high and busy low. A mode 0 item
//   writes one cell's obstacle bit at that edge, gives no result and leaves
//   busy low, so writes can follow back to back. A mode 1 item runs a shortest
//   path search from the item's cell to its goal on a 4-connected grid of
//   grid_width by grid_height cells; busy stays high until the last result is
//   issued, and the next item can be taken while that result is on the ports.
//   Results appear on o_result, each marked by o_strobe high for a single
//   cycle, start cell first, last flag on the goal. The receiver cannot
//   stall: every strobed item is taken. An unreachable goal gives one
//   result, the goal, with reached low.
//   A search seeds the queue, then per pop scans the open queue for the
//   minimum, moves the later entries up to close the gap and relaxes the
//   four neighbors, skipping those off the grid; then it checks the goal,
//   walks the path back from the goal and outputs it from the start cell.
//   The queue scan dominates and grows with its fill. Reset empties the
//   queue, marks all cells passable and sets the grid to 8 by 8; no clearing
//   pass. Registers: grid_width at 0, grid_height at 4, to be written by the
//   user through APB only while the block is idle; the block does not enforce it.
module grid_astar_path_search #(
    parameter int MAX_DIM     = gasp_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = gasp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  gasp_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output gasp_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import gasp_pkg::*;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [3:0] r_grid_w, r_grid_h;
    t_cmd       cmd;
    t_stat      stat;

    // register file; pready is tied high, writes land on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= 4'd8;
            r_grid_h <= 4'd8;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_WIDTH:  r_grid_w <= pwdata[3:0];
                REG_HEIGHT: r_grid_h <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = {28'd0, (paddr[2] == REG_HEIGHT) ? r_grid_h : r_grid_w};

    gasp_ctrl u_ctrl (
        .i_clk,
        .i_rst_n,
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    gasp_dp #(.MAX_DIM(MAX_DIM), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk,
        .i_rst_n,
        .i_cmd   (cmd),
        .i_item  (i_item),
        .i_grid_w(r_grid_w),
        .i_grid_h(r_grid_h),
        .o_stat  (stat),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );
endmodule
